// File: rtl/core/ppcq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppcq_pkg
// Shared types and constants for the projection pixel calibrate/quantize block.
// ----------------------------------------------------------------------------
package ppcq_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int GEOM_W  = 13;
    localparam int POS_W   = 12;
    localparam int ADDR_W  = 24;
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // visual: byte = floor(m / 100), m < 25600, by reciprocal 5243 / 2^19
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam logic [32:0] VIS_SAT_LIM = 33'd25600;
    localparam logic [50:0] VIS_BIAS    = 51'd6553600;

    typedef enum logic [CIDX_W-1:0] {
        REG_GAIN      = 3'd0,
        REG_OFFSET    = 3'd1,
        REG_VISUAL    = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_STEP_INV  = 3'd4,
        REG_WIDTH     = 3'd5,
        REG_HEIGHT    = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        logic               visual_mode;
        logic signed [31:0] threshold;
        logic [31:0]        step_inverse;
        logic [GEOM_W-1:0]  width;
        logic [GEOM_W-1:0]  height;
    } t_cfg;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic [ADDR_W-1:0]       addr;
        logic                    eoi;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              eoi;
        logic              empty;
    } t_tag;

endpackage
`default_nettype wire

// File: rtl/core/ppcq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppcq_front
// Accepts input beats, drops cropped and out-of-frame pixels, forms the
// flipped destination address and end-of-image flag, and pushes to the queue.
// ----------------------------------------------------------------------------
module ppcq_front import ppcq_pkg::*; (
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [PIX_W-1:0] i_pixel,
    input  wire logic [POS_W-1:0]        i_row,
    input  wire logic [POS_W-1:0]        i_column,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_q_full,
    output logic                         o_push,
    output t_item                        o_item
);

    logic [GEOM_W-1:0] w;
    logic [GEOM_W-1:0] h;
    logic [GEOM_W-1:0] wm1;
    logic [GEOM_W-1:0] hm1;
    logic [GEOM_W-1:0] r_ext;
    logic [GEOM_W-1:0] c_ext;
    logic [POS_W-1:0]  flip_row;
    logic              keep;
    logic [2*POS_W-1:0] prod;

    always_comb begin
        w = (i_cfg.width > GEOM_W'(MAX_WIDTH)) ? GEOM_W'(MAX_WIDTH) : i_cfg.width;
        h = (i_cfg.height > GEOM_W'(MAX_HEIGHT)) ? GEOM_W'(MAX_HEIGHT) : i_cfg.height;
        wm1 = w - GEOM_W'(1);
        hm1 = h - GEOM_W'(1);
        r_ext = {1'b0, i_row};
        c_ext = {1'b0, i_column};
        keep = (w >= GEOM_W'(2)) && (h != '0) && (r_ext < h) && (c_ext < wm1);
        flip_row = POS_W'(hm1 - r_ext);
        prod = flip_row * wm1[POS_W-1:0];
        o_item.pixel = i_pixel;
        o_item.addr  = ADDR_W'(prod) + ADDR_W'(i_column);
        o_item.eoi   = (r_ext == hm1) && (c_ext == w - GEOM_W'(2));
        o_stall = i_q_full;
        o_push  = i_valid && !i_q_full && keep;
    end

endmodule
`default_nettype wire

// File: rtl/core/ppcq_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppcq_queue
// Short FIFO that decouples the classify front from the arithmetic back.
// ----------------------------------------------------------------------------
module ppcq_queue import ppcq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_avail,
    output t_item      o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (do_pop) r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule
`default_nettype wire

// File: rtl/core/ppcq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppcq_back
// Five-stage calibrate and quantize pipeline: multiply by gain, add offset,
// visual/thermal pre-scale, reciprocal and step multiplies, final select.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module ppcq_back import ppcq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_avail,
    input  wire t_item i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [7:0]        o_value,
    output logic [ADDR_W-1:0] o_address,
    output logic              o_eoi
);

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tag r_t1, r_t2, r_t3, r_t4;

    logic signed [47:0] r_p1;
    logic signed [49:0] r_v2_val;

    logic        r_vneg3, r_vovf3;
    logic [14:0] r_m3;
    logic        r_tbelow3, r_tbig3;
    logic [15:0] r_dhi3;
    logic [31:0] r_dlo3;

    logic        r_vneg4, r_vovf4, r_tbelow4, r_tbig4;
    logic [27:0] r_vq4;
    logic [47:0] r_hs4;
    logic [63:0] r_ls4;

    logic [7:0]        r_val5;
    logic [ADDR_W-1:0] r_addr5;
    logic              r_eoi5;

    logic signed [15:0] pix_pos;
    t_tag               tag_in;
    logic signed [50:0] num;
    logic signed [50:0] dval;
    logic signed [49:0] tval;
    logic [65:0]        s66;
    logic               tsat;
    logic [7:0]         vis_b;
    logic [7:0]         thr_b;
    logic [7:0]         val;

    assign en      = !r_v5 || !i_stall;
    assign o_pop   = en;
    assign o_valid = r_v5;
    assign o_value   = r_val5;
    assign o_address = r_addr5;
    assign o_eoi     = r_eoi5;

    always_comb begin
        pix_pos      = {1'b0, i_item.pixel[PIX_W-2:0]};
        tag_in.addr  = i_item.addr;
        tag_in.eoi   = i_item.eoi;
        tag_in.empty = i_item.pixel[PIX_W-1];

        num  = (51'(r_v2_val) <<< 1) + $signed(VIS_BIAS);
        tval = {{10{i_cfg.threshold[31]}}, i_cfg.threshold, 8'b0};
        dval = 51'(r_v2_val) - 51'(tval);

        s66  = {2'b0, r_ls4} + (66'd1 << 39) + {18'b0, r_hs4[15:0], 32'b0};
        tsat = (|r_hs4[47:16]) || (|s66[65:48]);

        if (r_vneg4) vis_b = 8'd0;
        else if (r_vovf4) vis_b = 8'd255;
        else vis_b = r_vq4[26:19];

        if (r_tbelow4) thr_b = 8'd0;
        else if (r_tbig4 || tsat) thr_b = 8'd255;
        else thr_b = s66[47:40];

        if (r_t4.empty) val = 8'd0;
        else if (i_cfg.visual_mode) val = vis_b;
        else val = thr_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_avail;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= tag_in;
            r_p1 <= pix_pos * i_cfg.gain;

            r_t2     <= r_t1;
            r_v2_val <= 50'(r_p1) + {{10{i_cfg.offset[31]}}, i_cfg.offset, 8'b0};

            r_t3      <= r_t2;
            r_vneg3   <= num[50];
            r_vovf3   <= (num[49:17] >= VIS_SAT_LIM);
            r_m3      <= num[31:17];
            r_tbelow3 <= dval[50];
            r_tbig3   <= |dval[49:48];
            r_dhi3    <= dval[47:32];
            r_dlo3    <= dval[31:0];

            r_t4      <= r_t3;
            r_vneg4   <= r_vneg3;
            r_vovf4   <= r_vovf3;
            r_tbelow4 <= r_tbelow3;
            r_tbig4   <= r_tbig3;
            r_vq4     <= r_m3 * RECIP_100;
            r_hs4     <= r_dhi3 * i_cfg.step_inverse;
            r_ls4     <= r_dlo3 * i_cfg.step_inverse;

            r_val5  <= val;
            r_addr5 <= r_t4.addr;
            r_eoi5  <= r_t4.eoi;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/projection_pixel_calibrate_quantize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// projection_pixel_calibrate_quantize
// Calibrates signed projection pixels and quantizes them to bytes with a
// row-flipped, last-column-cropped destination address.
// ----------------------------------------------------------------------------
// Sustains one pixel beat per cycle while the queue is not full. The front
// classifies and addresses a beat in the cycle it is accepted and writes it
// to a 4-beat queue; the back is a 5-stage pipeline whose last stage is the
// output register. The back pipeline advances as a whole whenever its output
// register is empty or being taken; input stall rises only when the queue is
// full. Cropped or out-of-frame pixels produce no output beat. Configuration
// must be written only while idle; the block itself does not enforce this.
module projection_pixel_calibrate_quantize import ppcq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CIDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [PIX_W-1:0] i_pixel,
    input  wire logic [POS_W-1:0]        i_row,
    input  wire logic [POS_W-1:0]        i_column,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [7:0]                   o_out_value,
    output logic [ADDR_W-1:0]            o_out_address,
    output logic                         o_end_of_image
);

    t_cfg  r_cfg;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_avail;
    t_item f_item;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain         <= 32'sh0100_0000;
            r_cfg.offset       <= '0;
            r_cfg.visual_mode  <= 1'b0;
            r_cfg.threshold    <= -32'sd196608;
            r_cfg.step_inverse <= 32'd524288;
            r_cfg.width        <= GEOM_W'(4096);
            r_cfg.height       <= GEOM_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN:      r_cfg.gain         <= i_cfg_data;
                REG_OFFSET:    r_cfg.offset       <= i_cfg_data;
                REG_VISUAL:    r_cfg.visual_mode  <= i_cfg_data[0];
                REG_THRESHOLD: r_cfg.threshold    <= i_cfg_data;
                REG_STEP_INV:  r_cfg.step_inverse <= i_cfg_data;
                REG_WIDTH:     r_cfg.width        <= i_cfg_data[GEOM_W-1:0];
                REG_HEIGHT:    r_cfg.height       <= i_cfg_data[GEOM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppcq_front u_front (
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pixel  (i_pixel),
        .i_row    (i_row),
        .i_column (i_column),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    ppcq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    ppcq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_avail   (q_avail),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_value   (o_out_value),
        .o_address (o_out_address),
        .o_eoi     (o_end_of_image)
    );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for projection_pixel_calibrate_quantize. A behavioral
// predictor computes the quantized byte, flipped destination address and
// end-of-image flag for every accepted pixel beat; a monitor compares each
// output beat in order. Directed cases cover extremes of the calibration and
// geometry registers, then randomized settings run with random idling on
// both sides, a long receiver hold-off and a final stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;
    import ppcq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE      = 24;
    localparam int LONG_HOLD   = 300;

    typedef struct {
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        logic               visual;
        logic signed [31:0] threshold;
        logic [31:0]        step_inv;
        logic [GEOM_W-1:0]  width;
        logic [GEOM_W-1:0]  height;
    } t_calib_regs;

    typedef struct {
        logic [7:0]        value;
        logic [ADDR_W-1:0] address;
        logic              eoi;
    } t_pixel_beat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [PIX_W-1:0] i_pixel = '0;
    logic [POS_W-1:0]        i_row = '0;
    logic [POS_W-1:0]        i_column = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [7:0]              o_out_value;
    logic [ADDR_W-1:0]       o_out_address;
    logic                    o_end_of_image;

    t_calib_regs cal;
    t_pixel_beat expected_pixels[$];
    int          mismatch_count = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          cycles = 0;

    projection_pixel_calibrate_quantize dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .i_row          (i_row),
        .i_column       (i_column),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_value    (o_out_value),
        .o_out_address  (o_out_address),
        .o_end_of_image (o_end_of_image)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit predict_pixel(input logic signed [PIX_W-1:0] pix,
                                         input logic [POS_W-1:0] row,
                                         input logic [POS_W-1:0] col,
                                         output t_pixel_beat beat);
        int          w;
        int          h;
        longint      v24;
        longint      num;
        longint      t24;
        logic [63:0] diff;
        logic [95:0] scaled;
        logic [7:0]  qbyte;
        w = (int'(cal.width) > MAX_WIDTH) ? MAX_WIDTH : int'(cal.width);
        h = (int'(cal.height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cal.height);
        beat = '{value: '0, address: '0, eoi: 1'b0};
        if (w < 2 || h == 0 || int'(row) >= h || int'(col) >= w - 1) begin
            return 1'b0;
        end
        qbyte = '0;
        if (pix >= 0) begin
            v24 = longint'(pix) * longint'(cal.gain) + longint'(cal.offset) * 64'sd256;
            if (cal.visual) begin
                num = 2 * v24 + 64'sd6553600;
                if (num < 0) begin
                    qbyte = '0;
                end else if (num / 64'sd13107200 > 255) begin
                    qbyte = 8'd255;
                end else begin
                    qbyte = 8'(num / 64'sd13107200);
                end
            end else begin
                t24 = longint'(cal.threshold) * 64'sd256;
                if (v24 >= t24) begin
                    diff   = 64'(v24 - t24);
                    scaled = {32'd0, diff} * {64'd0, cal.step_inv} + (96'd1 << 39);
                    scaled = scaled >> 40;
                    qbyte  = (scaled > 96'd255) ? 8'd255 : scaled[7:0];
                end
            end
        end
        beat.value   = qbyte;
        beat.address = ADDR_W'((h - 1 - int'(row)) * (w - 1) + int'(col));
        beat.eoi     = (int'(row) == h - 1) && (int'(col) == w - 2);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100) begin
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_GAIN:      cal.gain = data;
            REG_OFFSET:    cal.offset = data;
            REG_VISUAL:    cal.visual = data[0];
            REG_THRESHOLD: cal.threshold = data;
            REG_STEP_INV:  cal.step_inv = data;
            REG_WIDTH:     cal.width = data[GEOM_W-1:0];
            REG_HEIGHT:    cal.height = data[GEOM_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Valid stays high from one beat to the next unless a gap is taken.
    task automatic send_pixel(input logic signed [PIX_W-1:0] pix,
                              input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col);
        int          gap;
        t_pixel_beat beat;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_pixel  <= pix;
        i_row    <= row;
        i_column <= col;
        do @(posedge i_clk); while (o_stall);
        if (predict_pixel(pix, row, col, beat)) begin
            expected_pixels.push_back(beat);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        int                      w;
        int                      h;
        logic signed [PIX_W-1:0] pix;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        w = (int'(cal.width) > MAX_WIDTH) ? MAX_WIDTH : int'(cal.width);
        h = (int'(cal.height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cal.height);
        case ($urandom_range(0, 7))
            0, 1: pix = PIX_W'($urandom_range(32768, 65535));
            2:    pix = PIX_W'($urandom());
            default: pix = PIX_W'($urandom_range(0, 32767));
        endcase
        if (w > 0 && h > 0 && $urandom_range(0, 19) > 2) begin
            row = POS_W'($urandom_range(0, h - 1));
            col = POS_W'($urandom_range(0, w - 1));
        end else begin
            row = POS_W'($urandom());
            col = POS_W'($urandom());
        end
        send_pixel(pix, row, col);
    endtask

    task automatic randomize_settings();
        write_reg(REG_GAIN, ($urandom_range(0, 3) == 0) ? $urandom() :
                  32'h0080_0000 + $urandom_range(0, 32'h0100_0000));
        write_reg(REG_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom() :
                  32'($urandom_range(0, 6553600)) - 32'd3276800);
        write_reg(REG_VISUAL, $urandom_range(0, 1));
        write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ? $urandom() :
                  32'($urandom_range(0, 13107200)) - 32'd3276800);
        write_reg(REG_STEP_INV, ($urandom_range(0, 3) == 0) ? $urandom() :
                  $urandom_range(1, 32'h0010_0000));
        case ($urandom_range(0, 7))
            0, 1:    write_reg(REG_WIDTH, 32'd4096);
            2:       write_reg(REG_WIDTH, $urandom_range(4097, 8191));
            3, 4:    write_reg(REG_WIDTH, $urandom_range(2, 64));
            default: write_reg(REG_WIDTH, $urandom_range(2, 4096));
        endcase
        case ($urandom_range(0, 7))
            0, 1:    write_reg(REG_HEIGHT, 32'd4096);
            2:       write_reg(REG_HEIGHT, $urandom_range(4097, 8191));
            3, 4:    write_reg(REG_HEIGHT, $urandom_range(1, 64));
            default: write_reg(REG_HEIGHT, $urandom_range(1, 4096));
        endcase
    endtask

    // Reset settings: thermal, threshold -3.0, step 8.0, full 4096x4096 frame.
    task automatic test_default_thermal();
        send_pixel(16'sd0, 12'd0, 12'd0);
        send_pixel(16'sd32767, 12'd4095, 12'd4094);
        send_pixel(-16'sd32768, 12'd10, 12'd5);
        send_pixel(-16'sd1, 12'd4095, 12'd0);
        send_pixel(16'sd5, 12'd0, 12'd4095);
        send_pixel(16'sd100, 12'd2048, 12'd2047);
    endtask

    task automatic test_visual_rounding();
        wait_for_results();
        write_reg(REG_VISUAL, 32'd1);
        write_reg(REG_OFFSET, 32'd12800);    // pixel 0 lands exactly on a half
        send_pixel(16'sd0, 12'd1, 12'd1);
        send_pixel(16'sd1, 12'd2, 12'd2);
        send_pixel(16'sd100, 12'd3, 12'd3);
        wait_for_results();
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        send_pixel(16'sd32767, 12'd4, 12'd4);
        wait_for_results();
        write_reg(REG_GAIN, 32'h8000_0000);
        write_reg(REG_OFFSET, 32'h8000_0000);
        send_pixel(16'sd32767, 12'd5, 12'd5);
        send_pixel(16'sd0, 12'd6, 12'd6);
    endtask

    task automatic test_thermal_edges();
        wait_for_results();
        write_reg(REG_VISUAL, 32'd0);
        write_reg(REG_GAIN, 32'h0100_0000);
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_THRESHOLD, 32'd100 << 16);
        write_reg(REG_STEP_INV, 32'd1);
        send_pixel(16'sd100, 12'd7, 12'd7);
        send_pixel(16'sd99, 12'd8, 12'd8);
        send_pixel(16'sd32767, 12'd9, 12'd9);
        wait_for_results();
        write_reg(REG_STEP_INV, 32'd0);
        send_pixel(16'sd30000, 12'd10, 12'd10);
        wait_for_results();
        write_reg(REG_STEP_INV, 32'hFFFF_FFFF);
        send_pixel(16'sd101, 12'd11, 12'd11);
        wait_for_results();
        write_reg(REG_STEP_INV, 32'h0001_0000);
        write_reg(REG_THRESHOLD, 32'h8000_0000);
        send_pixel(16'sd0, 12'd12, 12'd12);
        wait_for_results();
        write_reg(REG_THRESHOLD, 32'h7FFF_FFFF);
        send_pixel(16'sd32767, 12'd13, 12'd13);
    endtask

    task automatic test_geometry();
        wait_for_results();
        write_reg(REG_WIDTH, 32'd2);
        write_reg(REG_HEIGHT, 32'd1);
        send_pixel(16'sd7, 12'd0, 12'd0);
        send_pixel(16'sd7, 12'd0, 12'd1);
        send_pixel(16'sd7, 12'd1, 12'd0);
        wait_for_results();
        write_reg(REG_WIDTH, 32'd1);
        send_pixel(16'sd7, 12'd0, 12'd0);
        wait_for_results();
        write_reg(REG_WIDTH, 32'd5);
        write_reg(REG_HEIGHT, 32'd0);
        send_pixel(16'sd7, 12'd0, 12'd0);
        wait_for_results();
        write_reg(REG_WIDTH, 32'd8191);
        write_reg(REG_HEIGHT, 32'd8191);
        send_pixel(16'sd7, 12'd4095, 12'd4094);
        send_pixel(16'sd7, 12'd0, 12'd0);
    endtask

    task automatic test_random_settings(input int phases, input int beats);
        for (int p = 0; p < phases; p++) begin
            wait_for_results();
            randomize_settings();
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            repeat (beats) send_random_pixel();
        end
    endtask

    // Receiver holds off while the sender keeps offering, then the sender
    // pauses until the block has drained before resuming.
    task automatic test_backpressure();
        wait_for_results();
        write_reg(REG_WIDTH, 32'd4096);
        write_reg(REG_HEIGHT, 32'd4096);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_requests++;
        repeat (20) send_random_pixel();
        wait_for_results();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (20) send_random_pixel();
    endtask

    task automatic test_no_idle(input int beats);
        wait_for_results();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        randomize_settings();
        repeat (beats) send_random_pixel();
    endtask

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_beats
        t_pixel_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected beat, address", 32'(o_out_address), '0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_value !== want.value)
                    report_mismatch("out_value", 32'(o_out_value), 32'(want.value));
                if (o_out_address !== want.address)
                    report_mismatch("out_address", 32'(o_out_address),
                                    32'(want.address));
                if (o_end_of_image !== want.eoi)
                    report_mismatch("end_of_image", 32'(o_end_of_image),
                                    32'(want.eoi));
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : run
        cal.gain      = 32'sh0100_0000;
        cal.offset    = '0;
        cal.visual    = 1'b0;
        cal.threshold = -32'sd196608;
        cal.step_inv  = 32'd524288;
        cal.width     = GEOM_W'(4096);
        cal.height    = GEOM_W'(4096);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_thermal();
        test_visual_rounding();
        test_thermal_edges();
        test_geometry();
        test_random_settings(6, 55);
        test_backpressure();
        test_no_idle(50);
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
